@@ rtl/core/assert_macros.svh @@
// assertion macros of the replacement engine, used by the controller module
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under the synchronous reset
`define RDCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the synchronous reset
`define RDCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rdcr_pkg.sv @@
// shared types and constants of the rrip dueling replacement engine
// no dependencies; imported by every module of the block except rdcr_ram
`default_nettype none

package rdcr_pkg;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int ADDR_BITS    = 48;
  localparam int SET_W        = 11;
  localparam int WAY_W        = 4;
  localparam int MASK_W       = 16;
  localparam int PC_W         = 8;
  localparam int RRV_W        = 2;
  localparam int CONF_W       = 2;
  localparam int LEADER_DEF   = 64;
  localparam int SIG_BITS_DEF = 6;
  localparam int SEL_MAX_DEF  = 1023;
  localparam int STRIDE       = 64;
  localparam logic [1:0]  RRV_MAX   = 2'd3;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam int WORD_W = NUM_WAYS * RRV_W + CONF_W + ADDR_BITS;

  typedef enum logic {
    OP_QUERY  = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } rdcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
  } rdcr_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/rdcr_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies; used for the per-set words and signature counters
`default_nettype none

module rdcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rdcr_ctrl.sv @@
// controller fsm: clearing pass, accept, execute and result handshake
// depends on rdcr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rdcr_ctrl
  import rdcr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire rdcr_sts_t sts,
  output rdcr_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_BUSY  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // command decode
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.accept = in_ready && in_valid;
    cmd.exec   = (state_r == ST_BUSY) && (!out_valid_r || out_ready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (cmd.accept) state_nxt = ST_BUSY;
      ST_BUSY:  if (cmd.exec) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RDCR_ASSERT_NEXT(a_exec_gives_result, cmd.exec, out_valid_r, "execute without result")
  `RDCR_ASSERT_NEXT(a_accept_goes_busy, cmd.accept, state_r == ST_BUSY, "accept not busy")
  `RDCR_ASSERT_NEXT(a_result_held, out_valid_r && !out_ready, out_valid_r, "result dropped")

endmodule

`default_nettype wire

@@ rtl/core/rdcr_dp.sv @@
// datapath: per-set ram, signature ram, victim search, dueling, lfsr
// depends on rdcr_pkg and rdcr_ram
`default_nettype none

module rdcr_dp
  import rdcr_pkg::*;
#(
  parameter int LEADER_COUNT = LEADER_DEF,
  parameter int SIG_BITS     = SIG_BITS_DEF,
  parameter int SELECTOR_MAX = SEL_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rdcr_cmd_t            cmd,
  output rdcr_sts_t                 sts,
  input  wire logic                 in_operation,
  input  wire logic [SET_W-1:0]     in_set_index,
  input  wire logic [WAY_W-1:0]     in_way_index,
  input  wire logic [MASK_W-1:0]    in_valid_mask,
  input  wire logic [ADDR_BITS-1:0] in_phys_address,
  input  wire logic [PC_W-1:0]      in_pc_low,
  input  wire logic                 in_was_hit,
  output logic      [WAY_W-1:0]     out_victim_way,
  output logic      [1:0]           out_insert_depth
);

  localparam int SIG_COUNT = 1 << SIG_BITS;
  localparam int CLR_N     = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
  localparam int CLR_W     = $clog2(CLR_N);
  localparam int SEL_W     = $clog2(SELECTOR_MAX + 1);
  localparam int RRV_BITS  = NUM_WAYS * RRV_W;
  localparam logic [SEL_W-1:0] SEL_MAX  = SEL_W'(SELECTOR_MAX);
  localparam logic [SEL_W-1:0] SEL_HALF = SEL_W'(SELECTOR_MAX / 2);
  localparam logic [SET_W:0]   LEAD1    = (SET_W+1)'(LEADER_COUNT);
  localparam logic [SET_W:0]   LEAD2    = (SET_W+1)'(2 * LEADER_COUNT);

  // latched item
  logic                 op_r;
  logic [SET_W-1:0]     set_r;
  logic [WAY_W-1:0]     way_r;
  logic [MASK_W-1:0]    mask_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SIG_BITS-1:0]  sig_r;
  logic                 hit_r;

  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic [15:0]      lfsr_r, lfsr_nxt;
  logic [CLR_W-1:0] clr_cnt_r;
  logic [WAY_W-1:0] victim_r, victim_nxt;
  logic [1:0]       depth_r, depth_nxt;

  logic [PC_W-1:0]     pc_hash;
  logic [11:0]         pc_hash_x;
  logic [SIG_BITS-1:0] in_sig;

  logic [WORD_W-1:0]    rd_word, wr_word, ram_wdata;
  logic                 ram_we;
  logic [SET_W-1:0]     ram_waddr;
  logic [1:0]           sig_q, sig_new, sig_wdata;
  logic                 sig_we;
  logic [SIG_BITS-1:0]  sig_waddr;

  logic [RRV_W-1:0]     rrv     [NUM_WAYS];
  logic [RRV_W-1:0]     rrv_new [NUM_WAYS];
  logic [CONF_W-1:0]    conf, conf_new;
  logic [ADDR_BITS-1:0] last;
  logic [ADDR_BITS:0]   last_up, addr_up;
  logic                 near;
  logic [RRV_W-1:0]     top, age;
  logic                 inv_found, at3_found, aged_found;
  logic [WAY_W-1:0]     inv_way, at3_way, aged_way;
  logic [RRV_W-1:0]     aged [NUM_WAYS];
  logic                 chance;
  logic [15:0]          lfsr_step;
  logic [RRV_BITS-1:0]  rrv_pack;

  // signature hash of the pc
  always_comb begin
    pc_hash   = in_pc_low ^ (in_pc_low >> 2);
    pc_hash_x = {4'd0, pc_hash};
    in_sig    = pc_hash_x[SIG_BITS-1:0];
  end

  // latch the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      set_r  <= in_set_index;
      way_r  <= in_way_index;
      mask_r <= in_valid_mask;
      addr_r <= in_phys_address;
      sig_r  <= in_sig;
      hit_r  <= in_was_hit;
    end
  end

  // unpack the set word
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrv[w] = rd_word[w*RRV_W +: RRV_W];
    end
    conf = rd_word[RRV_BITS +: CONF_W];
    last = rd_word[RRV_BITS+CONF_W +: ADDR_BITS];
  end

  // first invalid way, first way at max, largest value, aged values, first aged way at max
  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    at3_found = 1'b0;
    at3_way   = '0;
    top       = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!mask_r[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
      if (rrv[w] == RRV_MAX) begin
        at3_found = 1'b1;
        at3_way   = WAY_W'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrv[w] > top) top = rrv[w];
    end
    age = RRV_MAX - top;
    aged_found = 1'b0;
    aged_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      aged[w] = rrv[w] + age;
      if (aged[w] == RRV_MAX) begin
        aged_found = 1'b1;
        aged_way   = WAY_W'(w);
      end
    end
  end

  // stride detector: exact distance of one line either way
  always_comb begin
    last_up = {1'b0, last} + (ADDR_BITS+1)'(STRIDE);
    addr_up = {1'b0, addr_r} + (ADDR_BITS+1)'(STRIDE);
    near = (!last_up[ADDR_BITS] && last_up[ADDR_BITS-1:0] == addr_r) ||
           (!addr_up[ADDR_BITS] && addr_up[ADDR_BITS-1:0] == last);
    conf_new = conf;
    if (last != '0) begin
      if (near) begin
        if (conf != 2'd3) conf_new = conf + 2'd1;
      end else if (conf != 2'd0) begin
        conf_new = conf - 2'd1;
      end
    end
  end

  // bip coin from the lfsr
  always_comb begin
    lfsr_step = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[15:1]};
    chance    = (lfsr_step[4:0] == 5'd0);
  end

  // operation
  always_comb begin
    rrv_new    = rrv;
    victim_nxt = '0;
    depth_nxt  = '0;
    sel_nxt    = sel_r;
    lfsr_nxt   = lfsr_r;
    sig_new    = sig_q;
    wr_word    = rd_word;
    case (op_t'(op_r))
      OP_QUERY: begin
        if (conf >= 2'd2) begin
          if (inv_found) begin
            victim_nxt = inv_way;
          end else if (at3_found) begin
            victim_nxt = at3_way;
          end else begin
            for (int w = 0; w < NUM_WAYS; w++) rrv_new[w] = rrv[w] + 2'd1;
          end
        end else begin
          rrv_new    = aged;
          victim_nxt = aged_found ? aged_way : '0;
        end
      end
      default: begin
        if (hit_r) begin
          if (sig_q != 2'd3) sig_new = sig_q + 2'd1;
          rrv_new[way_r] = '0;
        end else begin
          if ({1'b0, set_r} < LEAD1) begin
            depth_nxt = RRV_MAX;
            if (sel_r != '0) sel_nxt = sel_r - SEL_W'(1);
          end else if ({1'b0, set_r} < LEAD2) begin
            lfsr_nxt  = lfsr_step;
            depth_nxt = chance ? 2'd0 : RRV_MAX;
            if (sel_r != SEL_MAX) sel_nxt = sel_r + SEL_W'(1);
          end else if (sel_r >= SEL_HALF) begin
            depth_nxt = RRV_MAX;
          end else begin
            lfsr_nxt  = lfsr_step;
            depth_nxt = chance ? 2'd0 : RRV_MAX;
          end
          rrv_new[way_r] = depth_nxt;
          if (sig_q != 2'd0) sig_new = sig_q - 2'd1;
        end
      end
    endcase
    for (int w = 0; w < NUM_WAYS; w++) rrv_pack[w*RRV_W +: RRV_W] = rrv_new[w];
    if (op_t'(op_r) == OP_UPDATE) begin
      wr_word = {addr_r, conf_new, rrv_pack};
    end else begin
      wr_word = {last, conf, rrv_pack};
    end
  end

  // ram write muxing: clearing pass or execute
  always_comb begin
    ram_we    = (cmd.clear && ({1'b0, clr_cnt_r} < (CLR_W+1)'(NUM_SETS))) || cmd.exec;
    ram_waddr = cmd.clear ? clr_cnt_r[SET_W-1:0] : set_r;
    ram_wdata = cmd.clear ? {{ADDR_BITS{1'b0}}, {CONF_W{1'b0}}, {NUM_WAYS{RRV_MAX}}}
                          : wr_word;
    sig_we    = (cmd.clear && ({1'b0, clr_cnt_r} < (CLR_W+1)'(SIG_COUNT))) ||
                (cmd.exec && op_t'(op_r) == OP_UPDATE);
    sig_waddr = cmd.clear ? clr_cnt_r[SIG_BITS-1:0] : sig_r;
    sig_wdata = cmd.clear ? 2'd1 : sig_new;
  end

  rdcr_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SETS)) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (in_set_index),
    .rdata (rd_word)
  );

  rdcr_ram #(.WIDTH(2), .DEPTH(SIG_COUNT)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (sig_waddr),
    .wdata (sig_wdata),
    .re    (cmd.accept),
    .raddr (in_sig),
    .rdata (sig_q)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= SEL_HALF;
      lfsr_r    <= LFSR_SEED;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + CLR_W'(1);
      if (cmd.exec) begin
        sel_r  <= sel_nxt;
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      victim_r <= victim_nxt;
      depth_r  <= depth_nxt;
    end
  end

  assign sts.clr_last     = (clr_cnt_r == CLR_W'(CLR_N - 1));
  assign out_victim_way   = victim_r;
  assign out_insert_depth = depth_r;

endmodule

`default_nettype wire

@@ rtl/core/rrip_dueling_cache_replacement.sv @@
// top level of the rrip set dueling replacement engine
// depends on rdcr_pkg, rdcr_ctrl and rdcr_dp
//
//   channel | ports                          | direction
//   in      | in_valid/in_ready + 7 fields   | query or update in
//   out     | out_valid/out_ready + 2 fields | victim way, insert depth out
//
// the set word is read on acceptance, then modified and written back when busy;
// no new item is accepted before that write. after reset a clearing pass over
// max(NUM_SETS, 2^SIG_BITS) addresses (2048) runs before the first transfer;
// in_ready is low meanwhile; a stalled result holds the write until out_ready
`default_nettype none

module rrip_dueling_cache_replacement
  import rdcr_pkg::*;
#(
  parameter int LEADER_COUNT = LEADER_DEF,
  parameter int SIG_BITS     = SIG_BITS_DEF,
  parameter int SELECTOR_MAX = SEL_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_operation,
  input  wire logic [SET_W-1:0]     in_set_index,
  input  wire logic [WAY_W-1:0]     in_way_index,
  input  wire logic [MASK_W-1:0]    in_valid_mask,
  input  wire logic [ADDR_BITS-1:0] in_phys_address,
  input  wire logic [PC_W-1:0]      in_pc_low,
  input  wire logic                 in_was_hit,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [WAY_W-1:0]     out_victim_way,
  output logic      [1:0]           out_insert_depth
);

  rdcr_cmd_t cmd;
  rdcr_sts_t sts;

  rdcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdcr_dp #(
    .LEADER_COUNT (LEADER_COUNT),
    .SIG_BITS     (SIG_BITS),
    .SELECTOR_MAX (SELECTOR_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_set_index     (in_set_index),
    .in_way_index     (in_way_index),
    .in_valid_mask    (in_valid_mask),
    .in_phys_address  (in_phys_address),
    .in_pc_low        (in_pc_low),
    .in_was_hit       (in_was_hit),
    .out_victim_way   (out_victim_way),
    .out_insert_depth (out_insert_depth)
  );

endmodule

`default_nettype wire

@@ bench/rrip_dueling_cache_replacement_tb.sv @@
// self-checking bench for the rrip set dueling replacement engine
// depends on rdcr_pkg and rrip_dueling_cache_replacement; drives directed then random traffic
`default_nettype none

module rrip_dueling_cache_replacement_tb;
  import rdcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_operation = 1'b0;
  logic [SET_W-1:0]     in_set_index = '0;
  logic [WAY_W-1:0]     in_way_index = '0;
  logic [MASK_W-1:0]    in_valid_mask = '0;
  logic [ADDR_BITS-1:0] in_phys_address = '0;
  logic [PC_W-1:0]      in_pc_low = '0;
  logic                 in_was_hit = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WAY_W-1:0]     out_victim_way;
  logic [1:0]           out_insert_depth;

  rrip_dueling_cache_replacement u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_set_index(in_set_index),
    .in_way_index(in_way_index), .in_valid_mask(in_valid_mask),
    .in_phys_address(in_phys_address), .in_pc_low(in_pc_low),
    .in_was_hit(in_was_hit),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_victim_way(out_victim_way), .out_insert_depth(out_insert_depth)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [WAY_W-1:0] victim;
    logic [1:0]       depth;
  } repl_result_t;

  // shadow replacement state
  logic [1:0]           rrv_q [NUM_SETS][NUM_WAYS];
  logic [1:0]           conf_q [NUM_SETS];
  logic [ADDR_BITS-1:0] last_addr_q [NUM_SETS];
  logic [1:0]           sig_ctr_q [64];
  logic [9:0]           psel_q;
  logic [15:0]          lfsr_q;

  repl_result_t expected_q[$];
  int  mismatch_count = 0;
  bit  stall_hold = 1'b0;
  bit  sending_done = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic bit bip_roll();
    logic fb;
    fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
    lfsr_q = {fb, lfsr_q[15:1]};
    return lfsr_q[4:0] == 5'd0;
  endfunction

  function automatic repl_result_t predict_replacement(
      input op_t op, input logic [SET_W-1:0] s, input logic [WAY_W-1:0] w,
      input logic [MASK_W-1:0] vmask, input logic [ADDR_BITS-1:0] addr,
      input logic [PC_W-1:0] pc, input logic hit);
    repl_result_t r;
    logic [1:0] top, depth;
    logic [5:0] sig;
    bit found;
    r = '0;
    found = 1'b0;
    if (op == OP_QUERY) begin
      if (conf_q[s] >= 2) begin
        for (int i = 0; i < NUM_WAYS; i++)
          if (!found && !vmask[i]) begin r.victim = WAY_W'(i); found = 1'b1; end
        for (int i = 0; i < NUM_WAYS; i++)
          if (!found && rrv_q[s][i] == RRV_MAX) begin
            r.victim = WAY_W'(i);
            found = 1'b1;
          end
        if (!found) begin
          for (int i = 0; i < NUM_WAYS; i++) rrv_q[s][i] = rrv_q[s][i] + 2'd1;
          r.victim = '0;
        end
      end else begin
        top = 0;
        for (int i = 0; i < NUM_WAYS; i++) if (rrv_q[s][i] > top) top = rrv_q[s][i];
        for (int i = 0; i < NUM_WAYS; i++) rrv_q[s][i] = rrv_q[s][i] + (RRV_MAX - top);
        for (int i = 0; i < NUM_WAYS; i++)
          if (!found && rrv_q[s][i] == RRV_MAX) begin
            r.victim = WAY_W'(i);
            found = 1'b1;
          end
      end
      return r;
    end
    // stride detector
    if (last_addr_q[s] != 0) begin
      if ((addr > last_addr_q[s] && addr - last_addr_q[s] == STRIDE) ||
          (last_addr_q[s] > addr && last_addr_q[s] - addr == STRIDE)) begin
        if (conf_q[s] < 3) conf_q[s]++;
      end else if (conf_q[s] > 0) conf_q[s]--;
    end
    last_addr_q[s] = addr;
    sig = pc[5:0] ^ pc[7:2];
    if (hit) begin
      if (sig_ctr_q[sig] < 3) sig_ctr_q[sig]++;
      rrv_q[s][w] = 0;
      return r;
    end
    if (s < LEADER_DEF) begin
      depth = RRV_MAX;
      if (psel_q > 0) psel_q--;
    end else if (s < 2 * LEADER_DEF) begin
      depth = bip_roll() ? 2'd0 : RRV_MAX;
      if (psel_q < SEL_MAX_DEF) psel_q++;
    end else if (psel_q >= SEL_MAX_DEF / 2) begin
      depth = RRV_MAX;
    end else begin
      depth = bip_roll() ? 2'd0 : RRV_MAX;
    end
    rrv_q[s][w] = depth;
    if (sig_ctr_q[sig] > 0) sig_ctr_q[sig]--;
    r.depth = depth;
    return r;
  endfunction

  // one input transfer, predicted on acceptance
  task automatic send_access(input op_t op, input logic [SET_W-1:0] s,
      input logic [WAY_W-1:0] w, input logic [MASK_W-1:0] vmask,
      input logic [ADDR_BITS-1:0] addr, input logic [PC_W-1:0] pc, input logic hit);
    int gap;
    repl_result_t pred;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // idle gap drops valid; back to back keeps it high
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_set_index <= s;
    in_way_index <= w;
    in_valid_mask <= vmask;
    in_phys_address <= addr;
    in_pc_low <= pc;
    in_was_hit <= hit;
    do @(posedge clk); while (!in_ready);
    pred = predict_replacement(op, s, w, vmask, addr, pc, hit);
    expected_q.insert(expected_q.size(), pred);
  endtask

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    return ADDR_BITS'({$urandom, $urandom});
  endfunction

  task automatic test_extremes();
    send_access(OP_QUERY, 0, 0, 16'hFFFF, 0, 0, 0);
    send_access(OP_QUERY, 11'h7FF, 15, 16'h0000, {ADDR_BITS{1'b1}}, 8'hFF, 1);
    send_access(OP_UPDATE, 0, 0, 0, 0, 0, 1);
    send_access(OP_UPDATE, 11'h7FF, 15, 16'hFFFF, {ADDR_BITS{1'b1}}, 8'hFF, 0);
    send_access(OP_UPDATE, 11'h7FF, 15, 0, {ADDR_BITS{1'b1}} - 64, 8'hAA, 1);
    send_access(OP_UPDATE, 5, 3, 0, 48'h1000, 8'h55, 0);
    send_access(OP_UPDATE, 70, 4, 0, 48'h2000, 8'h0F, 0);
    send_access(OP_UPDATE, 300, 9, 0, 48'h3000, 8'hF0, 0);
    send_access(OP_QUERY, 5, 0, 16'hFFFF, 0, 0, 0);
  endtask

  // stride run flips a set into streaming mode, then its queries
  task automatic test_streaming();
    logic [ADDR_BITS-1:0] a;
    a = 48'h8000;
    for (int i = 0; i < 5; i++) begin
      send_access(OP_UPDATE, 200, WAY_W'(i), 0, a, PC_W'(i), 1);
      a = (i == 3) ? a - 48'd64 : a + 48'd64;
    end
    send_access(OP_QUERY, 200, 0, 16'hFFF7, 0, 0, 0);
    send_access(OP_QUERY, 200, 0, 16'hFFFF, 0, 0, 0);
    send_access(OP_QUERY, 200, 0, 16'hFFFF, 0, 0, 0);
    for (int i = 0; i < NUM_WAYS; i++) send_access(OP_UPDATE, 200, WAY_W'(i), 0, a, 1, 1);
    send_access(OP_QUERY, 200, 0, 16'hFFFF, 0, 0, 0);
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    stall_hold = 1'b1;
    for (int i = 0; i < 12; i++)
      send_access(op_t'($urandom_range(0, 1)), SET_W'($urandom_range(0, 255)),
                  WAY_W'($urandom), MASK_W'($urandom), rand_addr(), PC_W'($urandom),
                  1'($urandom));
  endtask

  task automatic test_random();
    logic [SET_W-1:0] s;
    logic [ADDR_BITS-1:0] a;
    int kind;
    for (int n = 0; n < 700; n++) begin
      kind = $urandom_range(0, 9);
      // mostly a small pool of sets, leaders and followers, so state builds up
      s = (kind < 8) ? SET_W'($urandom_range(0, 159)) : SET_W'($urandom);
      if (s >= 128 && kind < 8) s = 11'd256 + s;
      if (kind < 3) begin
        a = {$urandom_range(0, 3), 6'd0} + 48'h10000;
        if ($urandom_range(0, 1))
          a = ($urandom_range(0, 1)) ? last_addr_q[s] + 48'd64 : last_addr_q[s] - 48'd64;
      end else a = rand_addr();
      send_access(op_t'($urandom_range(0, 2) != 0), s, WAY_W'($urandom),
                  MASK_W'($urandom), a, PC_W'($urandom), $urandom_range(0, 2) == 0);
    end
  endtask

  // receiver ready with random stalls, plus a long counted hold
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (stall_hold) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < 200) begin @(posedge clk); hold++; end
        stall_hold = 1'b0;
      end
      if (sending_done || $urandom_range(0, 3) != 0) out_ready <= 1'b1;
      else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(5, 25)) @(posedge clk);
      end else out_ready <= 1'b0;
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    repl_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", out_victim_way, 0);
      else begin
        exp_r = expected_q.pop_front();
        if (out_victim_way !== exp_r.victim)
          report_mismatch("victim_way", out_victim_way, exp_r.victim);
        if (out_insert_depth !== exp_r.depth)
          report_mismatch("insert_depth", out_insert_depth, exp_r.depth);
      end
    end
  end

  initial begin
    #5ms;
    $display("rrip_dueling_cache_replacement regression: fail");
    $finish;
  end

  initial begin
    for (int s = 0; s < NUM_SETS; s++) begin
      conf_q[s] = 0;
      last_addr_q[s] = 0;
      for (int w = 0; w < NUM_WAYS; w++) rrv_q[s][w] = RRV_MAX;
    end
    for (int i = 0; i < 64; i++) sig_ctr_q[i] = 1;
    psel_q = SEL_MAX_DEF / 2;
    lfsr_q = LFSR_SEED;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_streaming();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    sending_done = 1'b1;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0)
      $display("rrip_dueling_cache_replacement regression: pass");
    else
      $display("rrip_dueling_cache_replacement regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ rrip_dueling_cache_replacement.f @@
+incdir+rtl/core
rtl/core/rdcr_pkg.sv
rtl/core/rdcr_ram.sv
rtl/core/rdcr_ctrl.sv
rtl/core/rdcr_dp.sv
rtl/core/rrip_dueling_cache_replacement.sv
bench/rrip_dueling_cache_replacement_tb.sv
